// File: sv/ugcb_pkg.sv
`timescale 1ns / 1ps

package ugcb_pkg;

  localparam int MAX_ROWS_DEF = 64;

  localparam int REG_W   = 12;
  localparam int POS_W   = 16;
  localparam int EXT_W   = 15;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 2;
  localparam int CELL_W  = 24;
  localparam int CNT_W   = 12;

  // Box edges after widening; they span -65535 .. 65533.
  localparam int EDGE_W  = 18;
  localparam int MAG_W   = 17;

  localparam logic [REG_W-1:0] CELL_SIZE_RST   = 12'd32;
  localparam logic [REG_W-1:0] GRID_WIDTH_RST  = 12'd800;
  localparam logic [REG_W-1:0] GRID_HEIGHT_RST = 12'd600;

  localparam logic [IDX_W-1:0] REG_CELL_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = 2'd2;

  localparam logic [KIND_W-1:0] KIND_RECT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd1;

  // Order in which the shared divider works through its six quotients.
  localparam int SEL_W = 3;
  localparam int NUM_DIV = 6;
  localparam logic [SEL_W-1:0] SEL_COLS   = 3'd0;
  localparam logic [SEL_W-1:0] SEL_ROWS   = 3'd1;
  localparam logic [SEL_W-1:0] SEL_LEFT   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_RIGHT  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_TOP    = 3'd4;
  localparam logic [SEL_W-1:0] SEL_BOTTOM = 3'd5;

  typedef struct packed {
    logic             load;
    logic             div_start;
    logic [SEL_W-1:0] div_sel;
    logic             clamp;
    logic             setup;
    logic             emit;
  } ugcb_cmd_t;

  typedef struct packed {
    logic bad;
    logic div_done;
    logic empty;
    logic out_free;
    logic last;
  } ugcb_stat_t;

endpackage

// File: sv/ugcb_in_if.sv
`timescale 1ns / 1ps

interface ugcb_in_if;
  logic                             valid;
  logic                             ready;
  logic [ugcb_pkg::KIND_W-1:0]      shape_kind;
  logic signed [ugcb_pkg::POS_W-1:0] pos_x;
  logic signed [ugcb_pkg::POS_W-1:0] pos_y;
  logic [ugcb_pkg::EXT_W-1:0]       box_w;
  logic [ugcb_pkg::EXT_W-1:0]       box_h;
  logic [ugcb_pkg::EXT_W-1:0]       radius;

  modport source (output valid, shape_kind, pos_x, pos_y, box_w, box_h, radius,
                  input ready);
  modport sink (input valid, shape_kind, pos_x, pos_y, box_w, box_h, radius,
                output ready);
endinterface

// File: sv/ugcb_out_if.sv
`timescale 1ns / 1ps

interface ugcb_out_if;
  logic                        valid;
  logic                        ready;
  logic [ugcb_pkg::CELL_W-1:0] first_cell;
  logic [ugcb_pkg::CNT_W-1:0]  cell_count;
  logic                        clipped;
  logic                        last_row;

  modport source (output valid, first_cell, cell_count, clipped, last_row,
                  input ready);
  modport sink (input valid, first_cell, cell_count, clipped, last_row,
                output ready);
endinterface

// File: sv/ugcb_cfg_if.sv
`timescale 1ns / 1ps

interface ugcb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ugcb_pkg::IDX_W-1:0] index;
  logic [ugcb_pkg::REG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/uniform_grid_cell_binning.sv
`timescale 1ns / 1ps

// Uniform grid binning of one collider per request.
// in_ch carries a rectangle or a circle; the block bins its bounding box into the
// grid set up by cfg_ch (cell size, world width, world height) and sends one
// request on out_ch per covered grid row: first flat cell index, cell count,
// a clipped flag when rows past MAX_ROWS were dropped, and last_row on the final one.
// Unknown kinds, a zero cell size and boxes a cell or more off the grid give nothing.
// One item is worked on at a time; in_ch.ready is high only while the block is idle.
// Order of work: six quotients (columns, rows and four box edges) go one after
// another through a single restoring divider at one bit per cycle, then the box
// is clamped and the row generator is set up, and the rows follow one another
// without gaps while out_ch.ready is high.
// Results leave through an output register; while it holds a row and out_ch.ready
// is low the row generator waits and nothing is lost or repeated.
// cfg_ch is always ready and should be written only while the block is idle;
// index 3 is ignored. Reset (rst_n low, synchronous) restores cell size 32,
// width 800 and height 600 and empties the output register.

module uniform_grid_cell_binning #(
  parameter int MAX_ROWS = ugcb_pkg::MAX_ROWS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  ugcb_in_if.sink    in_ch,
  ugcb_out_if.source out_ch,
  ugcb_cfg_if.sink   cfg_ch
);

  ugcb_pkg::ugcb_cmd_t  cmd;
  ugcb_pkg::ugcb_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  ugcb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ugcb_dpath #(
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .shape_kind (in_ch.shape_kind),
    .pos_x      (in_ch.pos_x),
    .pos_y      (in_ch.pos_y),
    .box_w      (in_ch.box_w),
    .box_h      (in_ch.box_h),
    .radius     (in_ch.radius),
    .cfg_we     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .first_cell (out_ch.first_cell),
    .cell_count (out_ch.cell_count),
    .clipped    (out_ch.clipped),
    .last_row   (out_ch.last_row)
  );

endmodule

// File: sv/ugcb_div.sv
`timescale 1ns / 1ps

module ugcb_div #(
  parameter int NUM_W = 17,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: sv/ugcb_dpath.sv
`timescale 1ns / 1ps

module ugcb_dpath #(
  parameter int MAX_ROWS = ugcb_pkg::MAX_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ugcb_pkg::ugcb_cmd_t                 cmd,
  output ugcb_pkg::ugcb_stat_t                stat,
  // request payload
  input  logic [ugcb_pkg::KIND_W-1:0]         shape_kind,
  input  logic signed [ugcb_pkg::POS_W-1:0]   pos_x,
  input  logic signed [ugcb_pkg::POS_W-1:0]   pos_y,
  input  logic [ugcb_pkg::EXT_W-1:0]          box_w,
  input  logic [ugcb_pkg::EXT_W-1:0]          box_h,
  input  logic [ugcb_pkg::EXT_W-1:0]          radius,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [ugcb_pkg::IDX_W-1:0]          cfg_index,
  input  logic [ugcb_pkg::REG_W-1:0]          cfg_data,
  // result register
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ugcb_pkg::CELL_W-1:0]         first_cell,
  output logic [ugcb_pkg::CNT_W-1:0]          cell_count,
  output logic                                clipped,
  output logic                                last_row
);

  localparam int EW = ugcb_pkg::EDGE_W;
  localparam int MW = ugcb_pkg::MAG_W;
  localparam int RW = ugcb_pkg::REG_W;
  localparam int CNTW = ugcb_pkg::CNT_W;
  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int NR_W = RW + 1;
  localparam int CELL_W_L = ugcb_pkg::CELL_W;

  // configuration registers
  logic [RW-1:0] cell_size_r, grid_width_r, grid_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r   <= ugcb_pkg::CELL_SIZE_RST;
      grid_width_r  <= ugcb_pkg::GRID_WIDTH_RST;
      grid_height_r <= ugcb_pkg::GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ugcb_pkg::REG_CELL_SIZE:   cell_size_r   <= cfg_data;
        ugcb_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data;
        ugcb_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // bounding box, held as left, right - 1, top, bottom - 1
  logic [ugcb_pkg::KIND_W-1:0] kind_r;
  logic signed [EW-1:0] left_r, rm1_r, top_r, bm1_r;
  logic signed [EW-1:0] px, py, ew, eh, er;

  assign px = EW'(pos_x);
  assign py = EW'(pos_y);
  assign ew = EW'({1'b0, box_w});
  assign eh = EW'({1'b0, box_h});
  assign er = EW'({1'b0, radius});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= shape_kind;
      if (shape_kind == ugcb_pkg::KIND_RECT) begin
        left_r <= px;
        rm1_r  <= px + ew - EW'(1);
        top_r  <= py;
        bm1_r  <= py + eh - EW'(1);
      end else begin
        left_r <= px - er;
        rm1_r  <= px + er - EW'(1);
        top_r  <= py - er;
        bm1_r  <= py + er - EW'(1);
      end
    end
  end

  // shared divider: magnitude in, sign restored afterwards (truncation toward zero)
  logic signed [EW-1:0] num_s;
  logic                 neg_r;
  logic [EW-1:0]        num_abs;
  logic                 div_done;
  logic [MW-1:0]        div_quo;
  logic signed [EW-1:0] quo_s;
  logic signed [EW-1:0] q_r [ugcb_pkg::NUM_DIV];

  always_comb begin
    case (cmd.div_sel)
      ugcb_pkg::SEL_COLS:   num_s = EW'({1'b0, grid_width_r});
      ugcb_pkg::SEL_ROWS:   num_s = EW'({1'b0, grid_height_r});
      ugcb_pkg::SEL_LEFT:   num_s = left_r;
      ugcb_pkg::SEL_RIGHT:  num_s = rm1_r;
      ugcb_pkg::SEL_TOP:    num_s = top_r;
      ugcb_pkg::SEL_BOTTOM: num_s = bm1_r;
      default:              num_s = '0;
    endcase
  end

  assign num_abs = num_s[EW-1] ? -num_s : num_s;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg_r <= num_s[EW-1];
    end
  end

  ugcb_div #(
    .NUM_W (MW),
    .DEN_W (RW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_abs[MW-1:0]),
    .den   (cell_size_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign quo_s = neg_r ? -EW'({1'b0, div_quo}) : EW'({1'b0, div_quo});

  always_ff @(posedge clk) begin
    if (div_done) begin
      q_r[cmd.div_sel] <= quo_s;
    end
  end

  // clamp to the grid
  logic [RW-1:0]        cols;
  logic signed [EW-1:0] cols_m1, rows_m1;
  logic signed [EW-1:0] x0_r, x1_r, y0_r, y1_r;

  assign cols    = q_r[ugcb_pkg::SEL_COLS][RW-1:0];
  assign cols_m1 = q_r[ugcb_pkg::SEL_COLS] - EW'(1);
  assign rows_m1 = q_r[ugcb_pkg::SEL_ROWS] - EW'(1);

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      x0_r <= q_r[ugcb_pkg::SEL_LEFT][EW-1] ? '0 : q_r[ugcb_pkg::SEL_LEFT];
      x1_r <= (q_r[ugcb_pkg::SEL_RIGHT] > cols_m1) ? cols_m1 : q_r[ugcb_pkg::SEL_RIGHT];
      y0_r <= q_r[ugcb_pkg::SEL_TOP][EW-1] ? '0 : q_r[ugcb_pkg::SEL_TOP];
      y1_r <= (q_r[ugcb_pkg::SEL_BOTTOM] > rows_m1) ? rows_m1 : q_r[ugcb_pkg::SEL_BOTTOM];
    end
  end

  // row generator setup
  logic signed [EW-1:0] nrows_full;
  logic [NR_W-1:0]      nrows;
  logic                 clip_now;
  logic signed [EW-1:0] count_full;
  logic [CELL_W_L-1:0]  start_cell;

  logic [CELL_W_L-1:0]  cur_r;
  logic [CNTW-1:0]      count_r;
  logic                 clip_r;
  logic [ROW_W-1:0]     remain_r;

  assign nrows_full = y1_r - y0_r + EW'(1);
  assign nrows      = nrows_full[NR_W-1:0];
  assign clip_now   = nrows > NR_W'(MAX_ROWS);
  assign count_full = x1_r - x0_r + EW'(1);
  assign start_cell = CELL_W_L'(y0_r[RW-1:0]) * CELL_W_L'(cols) + CELL_W_L'(x0_r[RW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      cur_r    <= start_cell;
      count_r  <= count_full[CNTW-1:0];
      clip_r   <= clip_now;
      remain_r <= clip_now ? ROW_W'(MAX_ROWS) : nrows[ROW_W-1:0];
    end else if (cmd.emit) begin
      cur_r    <= cur_r + CELL_W_L'(cols);
      remain_r <= remain_r - ROW_W'(1);
    end
  end

  // result register
  logic                 out_valid_r;
  logic [CELL_W_L-1:0]  first_cell_r;
  logic [CNTW-1:0]      cell_count_r;
  logic                 clipped_r;
  logic                 last_row_r;
  logic                 out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      first_cell_r <= cur_r;
      cell_count_r <= count_r;
      clipped_r    <= clip_r;
      last_row_r   <= remain_r == ROW_W'(1);
    end
  end

  assign out_valid  = out_valid_r;
  assign first_cell = first_cell_r;
  assign cell_count = cell_count_r;
  assign clipped    = clipped_r;
  assign last_row   = last_row_r;

  assign stat.bad      = (kind_r != ugcb_pkg::KIND_RECT && kind_r != ugcb_pkg::KIND_CIRCLE)
                         || cell_size_r == '0;
  assign stat.div_done = div_done;
  assign stat.empty    = (x0_r > x1_r) || (y0_r > y1_r);
  assign stat.out_free = out_free;
  assign stat.last     = remain_r == ROW_W'(1);

endmodule

// File: sv/ugcb_ctrl.sv
`timescale 1ns / 1ps

module ugcb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ugcb_pkg::ugcb_stat_t stat,
  output ugcb_pkg::ugcb_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_GO,
    S_WAIT,
    S_CLAMP,
    S_SETUP,
    S_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ugcb_pkg::SEL_W-1:0] sel_r, sel_nxt;

  always_comb begin
    state_nxt     = state_r;
    sel_nxt       = sel_r;
    cmd           = '0;
    cmd.div_sel   = sel_r;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        sel_nxt   = ugcb_pkg::SEL_COLS;
        state_nxt = stat.bad ? S_IDLE : S_GO;
      end
      S_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) begin
          if (sel_r == ugcb_pkg::SEL_BOTTOM) begin
            state_nxt = S_CLAMP;
          end else begin
            sel_nxt   = sel_r + 1'b1;
            state_nxt = S_GO;
          end
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = stat.empty ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= ugcb_pkg::SEL_COLS;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule
